FILE: hdl/rectilinear_trilinear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trilinear interpolator
// Concurrent assertion wrappers on clk and rst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RECTILINEAR_TRILINEAR_INTERPOLATOR_ASSERT_SVH
`define RECTILINEAR_TRILINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge out of reset.
`define RTI_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("interpolator assertion failed");
// A condition that implies another one on the following edge.
`define RTI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("interpolator assertion failed");
`else
`define RTI_ASSERT(label, cond)
`define RTI_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: hdl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, codes and types of the trilinear interpolator.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int AXIS_DEPTH  = 16;
    localparam int AXIS_AW     = $clog2(AXIS_DEPTH);
    localparam int SIZE_W      = 5;
    localparam int SIZE_RESET  = 16;
    localparam int COMPONENTS  = 3;
    localparam int COMP_W      = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int OUT_COMPS   = 3;
    localparam int FIELD_DEPTH = AXIS_DEPTH * AXIS_DEPTH * AXIS_DEPTH * COMPONENTS;
    localparam int FIELD_AW    = $clog2(FIELD_DEPTH);
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 17;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CW      = $clog2(DIV_STEPS);
    localparam int POS_W       = 14;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CORNER_W    = 3;
    localparam int PROD_W      = VAL_W + 1 + FRAC_W + 1;

    // Operation codes carried on the input kind field
    localparam logic [OP_W-1:0] OP_LOAD_X     = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_Y     = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_Z     = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_FIELD = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

    typedef enum logic [1:0] {RA_FIRST, RA_LAST, RA_MID} ra_t;

    typedef enum logic [2:0] {MV_NONE, MV_H0, MV_H1, MV_Y, MV_Z, MV_OUT} mv_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_AX_RD0, ST_AX_RDN, ST_AX_CAPN, ST_AX_CHK, ST_PROBE, ST_PCAP,
        ST_WIDTH, ST_DIV, ST_AX_NEXT, ST_ADDR1, ST_ADDR2, ST_ADDR3, ST_F_ISSUE,
        ST_F_CAP, ST_B_DIFF, ST_B_MUL, ST_B_ADD, ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic                load;
        ra_t                 ra_sel;
        logic                cap_tlo;
        logic                cap_thi;
        logic                check;
        logic                probe;
        logic                width;
        logic                div_step;
        logic                addr1;
        logic                addr2;
        logic                addr3;
        logic                cap_a;
        logic                cap_b;
        logic                diff;
        logic                mul;
        mv_t                 mv;
        logic                publish;
        axis_t               axis;
        axis_t               lvl;
        logic [CORNER_W-1:0] corner;
        logic [COMP_W-1:0]   comp;
    } dp_cmd_t;

    typedef struct packed {
        logic search_done;
        logic range_bad;
        logic width_zero;
        logic div_last;
        logic any_flag;
    } dp_stat_t;

    // Sizes below two act as two, above the table depth as the depth.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (s > SIZE_W'(AXIS_DEPTH))
            r = SIZE_W'(AXIS_DEPTH);
        return r;
    endfunction

endpackage

FILE: hdl/rti_ram.sv
// ----------------------------------------------------------------------------
// rti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/rti_dp.sv
// ----------------------------------------------------------------------------
// rti_dp
// Datapath: axis tables, field store, search, fraction divider and blender.
// ----------------------------------------------------------------------------
module rti_dp import rti_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic [OP_W-1:0]       op,
    input  logic [POS_W-1:0]      position,
    input  logic signed [VAL_W-1:0] load_value,
    input  logic signed [VAL_W-1:0] point_x,
    input  logic signed [VAL_W-1:0] point_y,
    input  logic signed [VAL_W-1:0] point_z,
    output logic [VAL_W-1:0]      value_x,
    output logic [VAL_W-1:0]      value_y,
    output logic [VAL_W-1:0]      value_z,
    output logic                  status
);

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SIZE_W-1:0] nx, ny, nz, n_sel;

    logic signed [VAL_W-1:0] px_reg, py_reg, pz_reg, p_sel;
    logic signed [VAL_W-1:0] tlo_reg, thi_reg;
    logic [AXIS_AW-1:0]      lo_reg, hi_reg, mid, last, span;
    logic [AXIS_AW:0]        mid_sum;
    logic [AXIS_AW-1:0]      ax_raddr;
    logic [VAL_W-1:0]        rd_x, rd_y, rd_z;
    logic signed [VAL_W-1:0] ax_rdata;
    logic                    we_x, we_y, we_z, we_f, ax_pos_ok, fld_pos_ok;

    logic [2:0]              oor_reg, zw_reg;
    logic [AXIS_AW-1:0]      cell_reg [3];
    logic [FRAC_W-1:0]       frac_reg [3];

    logic signed [VAL_W:0]   width;
    logic [VAL_W:0]          wid_reg;
    logic [VAL_W+1:0]        rem_reg;
    logic [VAL_W+1:0]        rem_sub;
    logic                    rem_ge;
    logic [FRAC_W-1:0]       q_reg, q_next;
    logic [DIV_CW-1:0]       cnt_reg;

    logic [FIELD_AW-1:0]     t_reg, sy_reg, sx_reg, base_reg, fld_raddr;
    logic [VAL_W-1:0]        fld_rdata;

    logic signed [VAL_W-1:0] a_reg, b_reg, h0_reg, h1_reg;
    logic signed [VAL_W:0]   diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [FRAC_W:0]  f_s;
    logic signed [VAL_W+1:0] sum_w;
    logic signed [VAL_W-1:0] sum;
    logic [VAL_W-1:0]        res_reg [OUT_COMPS];
    logic [VAL_W-1:0]        out_reg [OUT_COMPS];
    logic                    status_reg;

    // Size registers, clamped where they are used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(SIZE_RESET);
            size_y_reg <= SIZE_W'(SIZE_RESET);
            size_z_reg <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign nx = clamp_size(size_x_reg);
    assign ny = clamp_size(size_y_reg);
    assign nz = clamp_size(size_z_reg);

    // Load decode: writes land on the transfer itself
    assign ax_pos_ok  = ({1'b0, position} < (POS_W+1)'(AXIS_DEPTH));
    assign fld_pos_ok = ({1'b0, position} < (POS_W+1)'(FIELD_DEPTH));
    assign we_x = cmd.load && (op == OP_LOAD_X) && ax_pos_ok;
    assign we_y = cmd.load && (op == OP_LOAD_Y) && ax_pos_ok;
    assign we_z = cmd.load && (op == OP_LOAD_Z) && ax_pos_ok;
    assign we_f = cmd.load && (op == OP_LOAD_FIELD) && fld_pos_ok;

    // Per-axis selection of table, size and query coordinate
    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  begin n_sel = nx; p_sel = px_reg; ax_rdata = rd_x; end
            AXIS_Y:  begin n_sel = ny; p_sel = py_reg; ax_rdata = rd_y; end
            default: begin n_sel = nz; p_sel = pz_reg; ax_rdata = rd_z; end
        endcase
    end

    assign last    = AXIS_AW'(n_sel - SIZE_W'(1));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AXIS_AW:1];
    assign span    = hi_reg - lo_reg;

    always_comb
    begin
        case (cmd.ra_sel)
            RA_FIRST: ax_raddr = '0;
            RA_LAST:  ax_raddr = last;
            default:  ax_raddr = mid;
        endcase
    end

    rti_ram #(.WIDTH(VAL_W), .DEPTH(AXIS_DEPTH)) u_x_tab (
        .clk(clk), .we(we_x), .waddr(position[AXIS_AW-1:0]), .wdata(load_value),
        .raddr(ax_raddr), .rdata(rd_x)
    );
    rti_ram #(.WIDTH(VAL_W), .DEPTH(AXIS_DEPTH)) u_y_tab (
        .clk(clk), .we(we_y), .waddr(position[AXIS_AW-1:0]), .wdata(load_value),
        .raddr(ax_raddr), .rdata(rd_y)
    );
    rti_ram #(.WIDTH(VAL_W), .DEPTH(AXIS_DEPTH)) u_z_tab (
        .clk(clk), .we(we_z), .waddr(position[AXIS_AW-1:0]), .wdata(load_value),
        .raddr(ax_raddr), .rdata(rd_z)
    );

    // Cell width and one restoring division step
    assign width   = {thi_reg[VAL_W-1], thi_reg} - {tlo_reg[VAL_W-1], tlo_reg};
    assign rem_ge  = (rem_reg >= {1'b0, wid_reg});
    assign rem_sub = rem_ge ? (rem_reg - {1'b0, wid_reg}) : rem_reg;
    assign q_next  = {q_reg[FRAC_W-2:0], rem_ge};

    assign stat.search_done = (span <= AXIS_AW'(1));
    assign stat.range_bad   = (p_sel < tlo_reg) || (p_sel > thi_reg);
    assign stat.width_zero  = (width <= 0);
    assign stat.div_last    = (cnt_reg == DIV_CW'(DIV_STEPS - 1));
    assign stat.any_flag    = (|oor_reg) || (|zw_reg);

    // Axis search and fraction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg <= '0;
            zw_reg  <= '0;
        end
        else if (cmd.start)
        begin
            oor_reg <= '0;
            zw_reg  <= '0;
        end
        else
        begin
            if (cmd.check && stat.range_bad)
            begin
                oor_reg[cmd.axis] <= 1'b1;
            end
            if (cmd.width && stat.width_zero)
            begin
                zw_reg[cmd.axis] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
        if (cmd.cap_tlo)
        begin
            tlo_reg <= ax_rdata;
        end
        if (cmd.cap_thi)
        begin
            thi_reg <= ax_rdata;
            lo_reg  <= '0;
            hi_reg  <= last;
        end
        if (cmd.probe)
        begin
            if (p_sel < ax_rdata)
            begin
                hi_reg  <= mid;
                thi_reg <= ax_rdata;
            end
            else
            begin
                lo_reg  <= mid;
                tlo_reg <= ax_rdata;
            end
        end
        if (cmd.width)
        begin
            cell_reg[cmd.axis] <= lo_reg;
            wid_reg <= width;
            rem_reg <= {2'b00, VAL_W'(p_sel - tlo_reg)};
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[VAL_W:0], 1'b0};
            q_reg   <= q_next;
            cnt_reg <= cnt_reg + DIV_CW'(1);
            if (stat.div_last)
            begin
                frac_reg[cmd.axis] <= q_next;
            end
        end
    end

    // Field addressing: base of the cell and strides along each axis
    always_ff @(posedge clk)
    begin
        if (cmd.addr1)
        begin
            t_reg  <= FIELD_AW'(cell_reg[0]) * FIELD_AW'(ny) + FIELD_AW'(cell_reg[1]);
            sy_reg <= FIELD_AW'(nz) * FIELD_AW'(COMPONENTS);
        end
        if (cmd.addr2)
        begin
            t_reg  <= t_reg * FIELD_AW'(nz) + FIELD_AW'(cell_reg[2]);
            sx_reg <= FIELD_AW'(ny) * sy_reg;
        end
        if (cmd.addr3)
        begin
            base_reg <= t_reg * FIELD_AW'(COMPONENTS);
        end
    end

    assign fld_raddr = base_reg
                     + (cmd.corner[0] ? sx_reg : '0)
                     + (cmd.corner[1] ? sy_reg : '0)
                     + (cmd.corner[2] ? FIELD_AW'(COMPONENTS) : '0)
                     + FIELD_AW'(cmd.comp);

    rti_ram #(.WIDTH(VAL_W), .DEPTH(FIELD_DEPTH)) u_field (
        .clk(clk), .we(we_f), .waddr(position[FIELD_AW-1:0]), .wdata(load_value),
        .raddr(fld_raddr), .rdata(fld_rdata)
    );

    // Blend unit: a + floor((b - a) * f / 2^16)
    assign f_s   = $signed({1'b0, frac_reg[cmd.lvl]});
    assign sum_w = {{2{a_reg[VAL_W-1]}}, a_reg} + prod_reg[VAL_W+17:16];
    assign sum   = sum_w[VAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            a_reg <= fld_rdata;
        end
        if (cmd.cap_b)
        begin
            b_reg <= fld_rdata;
        end
        if (cmd.diff)
        begin
            diff_reg <= {b_reg[VAL_W-1], b_reg} - {a_reg[VAL_W-1], a_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= diff_reg * f_s;
        end
        case (cmd.mv)
            MV_H0:   h0_reg <= sum;
            MV_H1:   h1_reg <= sum;
            MV_Y:    begin a_reg <= h0_reg; b_reg <= sum; end
            MV_Z:    begin a_reg <= h1_reg; b_reg <= sum; end
            MV_OUT:  res_reg[cmd.comp] <= sum;
            default: ;
        endcase
        if (cmd.start)
        begin
            for (int i = 0; i < OUT_COMPS; i++)
            begin
                res_reg[i] <= '0;
            end
        end
    end

    // Result register towards the output channel
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            for (int i = 0; i < OUT_COMPS; i++)
            begin
                out_reg[i] <= res_reg[i];
            end
            status_reg <= |oor_reg;
        end
    end

    assign value_x = out_reg[0];
    assign value_y = out_reg[1];
    assign value_z = out_reg[2];
    assign status  = status_reg;

endmodule

FILE: hdl/rti_ctrl.sv
// ----------------------------------------------------------------------------
// rti_ctrl
// Controller: sequences search, division, fetch and blend for each query.
// ----------------------------------------------------------------------------
`include "rectilinear_trilinear_interpolator_assert.svh"

module rti_ctrl import rti_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] op,
    output logic            s_tready,
    input  logic            m_tready,
    output logic            m_tvalid,
    output dp_cmd_t         cmd,
    input  dp_stat_t        stat
);

    state_t              state_reg, state_next;
    axis_t               axis_reg, axis_next, lvl_reg, lvl_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            lvl_reg       <= AXIS_X;
            corner_reg    <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            lvl_reg       <= lvl_next;
            corner_reg    <= corner_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        lvl_next    = lvl_reg;
        corner_next = corner_reg;
        comp_next   = comp_reg;
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.lvl     = lvl_reg;
        cmd.corner  = corner_reg;
        cmd.comp    = comp_reg;
        cmd.ra_sel  = RA_MID;
        cmd.mv      = MV_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        axis_next  = AXIS_X;
                        state_next = ST_AX_RD0;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_AX_RD0:
            begin
                cmd.ra_sel = RA_FIRST;
                state_next = ST_AX_RDN;
            end
            ST_AX_RDN:
            begin
                cmd.cap_tlo = 1'b1;
                cmd.ra_sel  = RA_LAST;
                state_next  = ST_AX_CAPN;
            end
            ST_AX_CAPN:
            begin
                cmd.cap_thi = 1'b1;
                state_next  = ST_AX_CHK;
            end
            ST_AX_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.range_bad ? ST_AX_NEXT : ST_PROBE;
            end
            ST_PROBE:
            begin
                state_next = stat.search_done ? ST_WIDTH : ST_PCAP;
            end
            ST_PCAP:
            begin
                cmd.probe  = 1'b1;
                state_next = ST_PROBE;
            end
            ST_WIDTH:
            begin
                cmd.width  = 1'b1;
                state_next = stat.width_zero ? ST_AX_NEXT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_AX_NEXT;
                end
            end
            ST_AX_NEXT:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = stat.any_flag ? ST_DONE : ST_ADDR1;
                end
                else
                begin
                    axis_next  = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                    state_next = ST_AX_RD0;
                end
            end
            ST_ADDR1:
            begin
                cmd.addr1  = 1'b1;
                state_next = ST_ADDR2;
            end
            ST_ADDR2:
            begin
                cmd.addr2  = 1'b1;
                state_next = ST_ADDR3;
            end
            ST_ADDR3:
            begin
                cmd.addr3   = 1'b1;
                corner_next = '0;
                comp_next   = '0;
                state_next  = ST_F_ISSUE;
            end
            ST_F_ISSUE:
            begin
                state_next = ST_F_CAP;
            end
            ST_F_CAP:
            begin
                if (!corner_reg[0])
                begin
                    cmd.cap_a   = 1'b1;
                    corner_next = corner_reg + CORNER_W'(1);
                    state_next  = ST_F_ISSUE;
                end
                else
                begin
                    cmd.cap_b  = 1'b1;
                    lvl_next   = AXIS_X;
                    state_next = ST_B_DIFF;
                end
            end
            ST_B_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_B_MUL;
            end
            ST_B_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_B_ADD;
            end
            ST_B_ADD:
            begin
                case (lvl_reg)
                    AXIS_X:
                    begin
                        if (!corner_reg[1])
                        begin
                            cmd.mv      = MV_H0;
                            corner_next = corner_reg + CORNER_W'(1);
                            state_next  = ST_F_ISSUE;
                        end
                        else
                        begin
                            cmd.mv     = MV_Y;
                            lvl_next   = AXIS_Y;
                            state_next = ST_B_DIFF;
                        end
                    end
                    AXIS_Y:
                    begin
                        if (!corner_reg[2])
                        begin
                            cmd.mv      = MV_H1;
                            corner_next = corner_reg + CORNER_W'(1);
                            state_next  = ST_F_ISSUE;
                        end
                        else
                        begin
                            cmd.mv     = MV_Z;
                            lvl_next   = AXIS_Z;
                            state_next = ST_B_DIFF;
                        end
                    end
                    default:
                    begin
                        cmd.mv = MV_OUT;
                        if (comp_reg == COMP_W'(COMPONENTS - 1))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            comp_next   = comp_reg + COMP_W'(1);
                            corner_next = '0;
                            state_next  = ST_F_ISSUE;
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on publish, cleared once the result is transferred
    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    `RTI_ASSERT(a_publish_free, !cmd.publish || !out_valid_reg || m_tready)
    `RTI_ASSERT_NEXT(a_result_held, out_valid_reg && !m_tready, out_valid_reg)
    `RTI_ASSERT_NEXT(a_query_starts, accept && (op == OP_QUERY), state_reg == ST_AX_RD0)

endmodule

FILE: hdl/rectilinear_trilinear_interpolator.sv
// ----------------------------------------------------------------------------
// rectilinear_trilinear_interpolator
// Trilinear interpolation of a three-component field on a rectilinear grid.
// ----------------------------------------------------------------------------
// Load items (axis coordinates, field words) are written on their transfer,
// give no result and leave the block ready for the next item. A query with
// the point inside the grid works through each axis in turn: two end reads
// and a range check, binary-search probes through the registered table read
// port, a state to see the search is done, one for the cell width, a 17-step
// restoring divider for the fraction and one to move on; the field address
// is then formed, and each component takes eight field store reads and seven
// blends on one shared multiplier. Fewer entries on an axis need fewer
// probes, and a zero cell width skips the divider. A point outside every
// axis skips the search, the divider and the field reads. The block takes no
// item while a query is in progress, but a finished result may wait in the
// output register while the next item is accepted; a query that finishes
// while an older result still waits stalls until that result is transferred.
module rectilinear_trilinear_interpolator import rti_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // position[13:0], load_value[45:14], point_x[77:46], point_y[109:78],
    // point_z[141:110], zero fill[143:142]
    input  logic [143:0]         s_tdata,
    // op[2:0]
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value_x[31:0], value_y[63:32], value_z[95:64]
    output logic [95:0]          m_tdata,
    // status[0]
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [VAL_W-1:0] value_x, value_y, value_z;

    // Sequencer
    rti_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .op(s_tuser), .s_tready(s_tready),
        .m_tready(m_tready), .m_tvalid(m_tvalid),
        .cmd(cmd), .stat(stat)
    );

    // Stores and arithmetic
    rti_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(s_tuser),
        .position(s_tdata[13:0]),
        .load_value(s_tdata[45:14]),
        .point_x(s_tdata[77:46]),
        .point_y(s_tdata[109:78]),
        .point_z(s_tdata[141:110]),
        .value_x(value_x), .value_y(value_y), .value_z(value_z),
        .status(m_tuser)
    );

    assign m_tdata = {value_z, value_y, value_x};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trilinear interpolator testbench
// Loads axis tables and field words, then sends query points with random
// handshake gaps. An in-bench predictor works out each expected result,
// and every result transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
    import rti_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 250;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [31:0]      load_value;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      pz;
    } item_t;

    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        status;
    } answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [143:0]         s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    // Pending items, expected answers and the predictor's own copy of state
    item_t       pending_items[$];
    answer_t     expected_answers[$];
    item_t       cur_item;
    bit          cur_taken;
    bit          quiet;
    int          send_gap;
    int          recv_gap;
    int          fail_count;
    int          cycle_count;
    longint      axis_mem[3][AXIS_DEPTH];
    longint      field_mem[FIELD_DEPTH];
    logic [SIZE_W-1:0] size_reg[3];
    longint      gen_axis[3][AXIS_DEPTH];

    rectilinear_trilinear_interpolator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock
    always #5 clk = ~clk;

    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        if (s < 2)
            return 2;
        if (s > AXIS_DEPTH)
            return AXIS_DEPTH;
        return int'(s);
    endfunction

    // Binary search on one axis: 0 inside, 1 outside, 2 zero cell width
    function automatic int find_cell(input longint p, input int a, input int n,
                                     output int cell_idx, output longint frac);
        int lo;
        int hi;
        int mid;
        longint w;
        cell_idx = 0;
        frac = 0;
        lo = 0;
        hi = n - 1;
        if (p < axis_mem[a][0] || p > axis_mem[a][n-1])
            return 1;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (p < axis_mem[a][mid])
                hi = mid;
            else
                lo = mid;
        end
        w = axis_mem[a][hi] - axis_mem[a][lo];
        if (w <= 0)
            return 2;
        cell_idx = lo;
        frac = ((p - axis_mem[a][lo]) <<< 16) / w;
        return 0;
    endfunction

    // Weighted mix of two values, rounded towards minus infinity
    function automatic longint mix(input longint a, input longint b, input longint f);
        longint s;
        s = a * (65536 - f) + b * f;
        return s >>> 16;
    endfunction

    function automatic longint corner(input int ix, input int iy, input int iz, input int c,
                                      input int ny, input int nz);
        return field_mem[((ix * ny + iy) * nz + iz) * COMPONENTS + c];
    endfunction

    // Applies one accepted item to the predictor state
    task automatic apply_item(input item_t it);
        int nx;
        int ny;
        int nz;
        int cx;
        int cy;
        int cz;
        int rx;
        int ry;
        int rz;
        longint fx;
        longint fy;
        longint fz;
        longint v00;
        longint v01;
        longint v10;
        longint v11;
        longint r;
        longint res[3];
        answer_t ans;
        res = '{0, 0, 0};
        case (it.op)
            OP_LOAD_X, OP_LOAD_Y, OP_LOAD_Z:
            begin
                if (it.pos < AXIS_DEPTH)
                    axis_mem[int'(it.op)][it.pos] = longint'($signed(it.load_value));
            end
            OP_LOAD_FIELD:
            begin
                if (it.pos < FIELD_DEPTH)
                    field_mem[it.pos] = longint'($signed(it.load_value));
            end
            OP_QUERY:
            begin
                nx = eff_size(size_reg[0]);
                ny = eff_size(size_reg[1]);
                nz = eff_size(size_reg[2]);
                rx = find_cell(longint'($signed(it.px)), 0, nx, cx, fx);
                ry = find_cell(longint'($signed(it.py)), 1, ny, cy, fy);
                rz = find_cell(longint'($signed(it.pz)), 2, nz, cz, fz);
                ans.status = (rx == 1 || ry == 1 || rz == 1);
                if (rx == 0 && ry == 0 && rz == 0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        v00 = mix(corner(cx, cy, cz, c, ny, nz),
                                  corner(cx + 1, cy, cz, c, ny, nz), fx);
                        v01 = mix(corner(cx, cy, cz + 1, c, ny, nz),
                                  corner(cx + 1, cy, cz + 1, c, ny, nz), fx);
                        v10 = mix(corner(cx, cy + 1, cz, c, ny, nz),
                                  corner(cx + 1, cy + 1, cz, c, ny, nz), fx);
                        v11 = mix(corner(cx, cy + 1, cz + 1, c, ny, nz),
                                  corner(cx + 1, cy + 1, cz + 1, c, ny, nz), fx);
                        r = mix(mix(v00, v10, fy), mix(v01, v11, fy), fz);
                        if (r > 64'sd2147483647)
                            r = 64'sd2147483647;
                        if (r < -64'sd2147483648)
                            r = -64'sd2147483648;
                        res[c] = r;
                    end
                end
                ans.vx = res[0][31:0];
                ans.vy = res[1][31:0];
                ans.vz = res[2][31:0];
                expected_answers.push_back(ans);
            end
            default:
            begin
            end
        endcase
    endtask

    // Input side: an accepted transfer updates the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            apply_item(cur_item);
            cur_taken = 1;
        end
    end

    // Driver, fed from the pending queue, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || cur_taken))
        begin
            cur_taken = 0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                send_gap = $urandom_range(1, 17) - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                s_tdata  <= {2'b00, cur_item.pz, cur_item.py, cur_item.px,
                             cur_item.load_value, cur_item.pos};
                s_tuser  <= cur_item.op;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            recv_gap = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t ans;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result %h status %b", $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                ans = expected_answers.pop_front();
                if (m_tdata[31:0] !== ans.vx)
                begin
                    $display("%0t: value_x expected %h actual %h", $time, ans.vx, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== ans.vy)
                begin
                    $display("%0t: value_y expected %h actual %h", $time, ans.vy,
                             m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== ans.vz)
                begin
                    $display("%0t: value_z expected %h actual %h", $time, ans.vz,
                             m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tuser !== ans.status)
                begin
                    $display("%0t: status expected %b actual %b", $time, ans.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rectilinear_trilinear_interpolator test failed");
            $finish;
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input int pos, input logic [31:0] lv,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
        item_t it;
        it.op = op;
        it.pos = POS_W'(pos);
        it.load_value = lv;
        it.px = px;
        it.py = py;
        it.pz = pz;
        pending_items.push_back(it);
    endtask

    // Waits until every item has gone and every result has come
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        size_reg[int'(idx)] = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_axis(input int a, input int n, input int kind);
        longint v;
        logic [OP_W-1:0] op;
        op = (a == 0) ? OP_LOAD_X : ((a == 1) ? OP_LOAD_Y : OP_LOAD_Z);
        v = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        for (int i = 0; i < n; i++)
        begin
            // kind 0 strictly rising, 1 with repeats, 2 arbitrary order
            if (kind == 2)
                v = longint'($signed($urandom));
            else if (i > 0)
                v += (kind == 1 && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 18);
            gen_axis[a][i] = v;
            push_item(op, i, v[31:0], $urandom, $urandom, $urandom);
        end
    endtask

    task automatic load_field(input int words);
        logic [31:0] v;
        for (int i = 0; i < words; i++)
        begin
            case ($urandom_range(0, 9))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                default: v = $urandom;
            endcase
            push_item(OP_LOAD_FIELD, i, v, $urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_coord(input int a, input int n);
        longint lo;
        longint hi;
        longint p;
        lo = gen_axis[a][0];
        hi = gen_axis[a][n-1];
        case ($urandom_range(0, 11))
            0: p = gen_axis[a][$urandom_range(0, n - 1)];
            1: p = hi;
            2: p = (lo > -64'sd2147483648) ? lo - 1 : hi + 1;
            3: p = (hi < 64'sd2147483647) ? hi + 1 : lo - 1;
            default:
            begin
                if (hi >= lo)
                    p = lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
                else
                    p = lo;
            end
        endcase
        return p[31:0];
    endfunction

    // Noise items: any operation code at a random position
    function automatic logic [OP_W-1:0] OP_LOGIC_RANDOM();
        return OP_W'($urandom_range(0, 7));
    endfunction

    // One setting: sizes, tables, field words, then queries and some noise
    task automatic run_phase(input logic [SIZE_W-1:0] rx, input logic [SIZE_W-1:0] ry,
                             input logic [SIZE_W-1:0] rz, input int kind, input int queries,
                             input bit hold_mid);
        int n[3];
        drain();
        write_size(CFG_SIZE_X, rx);
        write_size(CFG_SIZE_Y, ry);
        write_size(CFG_SIZE_Z, rz);
        n[0] = eff_size(rx);
        n[1] = eff_size(ry);
        n[2] = eff_size(rz);
        for (int a = 0; a < 3; a++)
            load_axis(a, n[a], kind);
        load_field(n[0] * n[1] * n[2] * COMPONENTS);
        for (int q = 0; q < queries; q++)
        begin
            if (hold_mid && q == queries / 2)
                drain();
            if ($urandom_range(0, 9) == 0)
                push_item(OP_LOGIC_RANDOM(), $urandom_range(0, (1 << POS_W) - 1), $urandom,
                          $urandom, $urandom, $urandom);
            else
                push_item(OP_QUERY, $urandom_range(0, (1 << POS_W) - 1), $urandom,
                          pick_coord(0, n[0]), pick_coord(1, n[1]), pick_coord(2, n[2]));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_QUERY;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SIZE_X;
        cfg_data = '0;
        cur_taken = 0;
        quiet = 0;
        send_gap = 0;
        recv_gap = 0;
        fail_count = 0;
        cycle_count = 0;
        for (int a = 0; a < 3; a++)
        begin
            size_reg[a] = SIZE_W'(SIZE_RESET);
            for (int i = 0; i < AXIS_DEPTH; i++)
                axis_mem[a][i] = 0;
        end
        for (int i = 0; i < FIELD_DEPTH; i++)
            field_mem[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: axis extremes, exact ends, just outside, spare codes
        write_size(CFG_SIZE_X, 5'd2);
        write_size(CFG_SIZE_Y, 5'd2);
        write_size(CFG_SIZE_Z, 5'd2);
        gen_axis[0][0] = -64'sd2147483648;
        gen_axis[0][1] = 64'sd2147483647;
        push_item(OP_LOAD_X, 0, 32'h8000_0000, '0, '0, '0);
        push_item(OP_LOAD_X, 1, 32'h7FFF_FFFF, '0, '0, '0);
        push_item(OP_LOAD_Y, 0, 32'h0000_0000, '0, '0, '0);
        push_item(OP_LOAD_Y, 1, 32'h0001_0000, '0, '0, '0);
        push_item(OP_LOAD_Z, 0, 32'hFFFF_FFFB, '0, '0, '0);
        push_item(OP_LOAD_Z, 1, 32'h0007_0000, '0, '0, '0);
        load_field(8 * COMPONENTS);
        push_item(OP_QUERY, 0, '0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFB);
        push_item(OP_QUERY, 0, '0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0007_0000);
        push_item(OP_QUERY, 0, '0, 32'h0, 32'h0000_8000, 32'h0000_1234);
        push_item(OP_QUERY, 0, '0, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0);
        push_item(OP_QUERY, 0, '0, 32'h0, 32'h0, 32'h0007_0001);
        push_item(OP_QUERY, 16383, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_SPARE_A, 1, 32'h5555_5555, '0, '0, '0);
        push_item(OP_SPARE_B, 2, 32'hAAAA_AAAA, '0, '0, '0);
        push_item(OP_SPARE_C, 3, 32'h0, '0, '0, '0);
        push_item(OP_LOAD_X, 16383, 32'h0, '0, '0, '0);
        push_item(OP_LOAD_FIELD, FIELD_DEPTH, 32'h0, '0, '0, '0);
        push_item(OP_QUERY, 0, '0, 32'h4000_0000, 32'h0000_FFFF, 32'h0000_0001);

        // Random part over several size settings, the out-of-range codes too
        run_phase(5'd0, 5'd1, 5'd3, 1, 40, 0);
        run_phase(5'd2, 5'd16, 5'd2, 0, 50, 1);
        run_phase(5'd2, 5'd2, 5'd31, 1, 50, 0);
        run_phase(5'd4, 5'd3, 5'd2, 2, 40, 0);
        run_phase(5'd3, 5'd4, 5'd2, 0, 50, 0);
        run_phase(5'd17, 5'd2, 5'd2, 1, 30, 0);
        drain();
        quiet = 1;
        run_phase(5'd5, 5'd2, 5'd2, 0, 40, 0);

        while (pending_items.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("rectilinear_trilinear_interpolator test passed");
        else
            $display("rectilinear_trilinear_interpolator test failed");
        $finish;
    end

endmodule
